>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> hw/rtl/kctc_pkg.sv
// Types, codes and constants of the keypad countdown timer controller.
package kctc_pkg;

  localparam int unsigned TIME_W   = 23;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned KEYS     = 4;
  localparam int unsigned CFG_W    = 23;

  typedef enum logic [1:0] {
    MODE_SHOW = 2'd0,
    MODE_SET  = 2'd1,
    MODE_RUN  = 2'd2
  } mode_t;

  localparam logic [2:0] KEY_IDLE = 3'd0;
  localparam logic [2:0] KEY_GO   = 3'd1;
  localparam logic [2:0] KEY_SETK = 3'd2;
  localparam logic [2:0] KEY_UP   = 3'd3;
  localparam logic [2:0] KEY_DN   = 3'd4;

  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_BEEP     = 2'd1;
  localparam logic [1:0] CFG_ALARM    = 2'd2;
  localparam logic [1:0] CFG_MAX_TIME = 2'd3;

  localparam logic [3:0]        DEBOUNCE_RST = 4'd5;
  localparam logic [9:0]        BEEP_RST     = 10'd500;
  localparam logic [7:0]        ALARM_RST    = 8'd100;
  localparam logic [TIME_W-1:0] MAX_TIME_RST = 23'd5999000;
  localparam logic [TIME_W-1:0] TIME_DEFAULT = 23'd330000;

  localparam logic [3:0] COUNT_MAX  = 4'd15;
  localparam logic [2:0] BRIGHT_MAX = 3'd7;
  localparam logic [2:0] DIGIT_FIRST = 3'd1;
  localparam logic [2:0] DIGIT_LAST  = 3'd4;

  typedef struct packed {
    logic [3:0]        debounce_samples;
    logic [9:0]        beep_ticks;
    logic [7:0]        alarm_interval;
    logic [TIME_W-1:0] max_time;
  } cfg_t;

  // Key accepted by the debouncer on this tick.
  typedef struct packed {
    logic       hit;
    logic [2:0] key;
  } key_evt_t;

  typedef struct packed {
    logic [TIME_W-1:0] remaining_ms;
    logic [TIME_W-1:0] set_ms;
    mode_t             mode;
    logic [2:0]        blink_digit;
    logic              run_led;
    logic              beep;
    logic              relay;
    logic [2:0]        brightness;
  } result_t;

  // Edit step for digit 1..4: 1 s, 10 s, 1 min, 10 min.
  function automatic logic [STEP_W-1:0] step_ms(input logic [1:0] sel);
    logic [STEP_W-1:0] s;
    case (sel)
      2'd0:    s = 20'd1000;
      2'd1:    s = 20'd10000;
      2'd2:    s = 20'd60000;
      default: s = 20'd600000;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/kctc_debounce.sv
// Per-key debounce counters with self-lock.
module kctc_debounce
  import kctc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [2:0] key_code,
  input  logic [3:0] debounce_samples,
  output key_evt_t   evt
);

  logic       key_lock      [KEYS];
  logic       key_lock_next [KEYS];
  logic [3:0] key_count      [KEYS];
  logic [3:0] key_count_next [KEYS];
  logic [1:0] idx;

  always_comb begin
    idx = 2'(key_code - KEY_GO);
    key_lock_next  = key_lock;
    key_count_next = key_count;
    evt = '0;
    if (key_code >= KEY_GO && key_code <= KEY_DN) begin
      if (!key_lock[idx]) begin
        if (key_count[idx] < COUNT_MAX) key_count_next[idx] = key_count[idx] + 4'd1;
        if (key_count[idx] > debounce_samples) begin
          key_lock_next[idx]  = 1'b1;
          key_count_next[idx] = '0;
          evt.hit = 1'b1;
          evt.key = key_code;
        end
      end
    end else begin
      // no key (or an unused code): release everything
      for (int i = 0; i < KEYS; i++) begin
        key_lock_next[i]  = 1'b0;
        key_count_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEYS; i++) begin
        key_lock[i]  <= 1'b0;
        key_count[i] <= '0;
      end
    end else if (step) begin
      key_lock  <= key_lock_next;
      key_count <= key_count_next;
    end
  end

endmodule

>>> hw/rtl/kctc_ctrl.sv
// Mode handling, set-time editing, countdown, beeper and relay timing.
module kctc_ctrl
  import kctc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  key_evt_t evt,
  input  logic     alarm_in,
  input  cfg_t     cfg,
  output result_t  res_next
);

  mode_t             mode_reg, mode_reg_next;
  logic              running, running_next;
  logic [TIME_W-1:0] remaining, remaining_next;
  logic [TIME_W-1:0] preset, preset_next;
  logic [2:0]        edit_digit, edit_digit_next;
  logic [2:0]        pending_key, pending_key_next;
  logic [9:0]        beep_count, beep_count_next;
  logic              beep_flag, beep_flag_next;
  logic [7:0]        alarm_delay, alarm_delay_next;
  logic              relay_reg, relay_reg_next;
  logic [2:0]        bright_reg, bright_reg_next;

  logic [2:0]        pk;
  logic [STEP_W-1:0] stp;
  logic [TIME_W:0]   sum;
  logic [7:0]        ad_inc;

  always_comb begin
    mode_reg_next    = mode_reg;
    running_next     = running;
    remaining_next   = remaining;
    preset_next      = preset;
    edit_digit_next  = edit_digit;
    beep_count_next  = beep_count;
    beep_flag_next   = beep_flag;
    alarm_delay_next = alarm_delay;
    relay_reg_next   = relay_reg;
    bright_reg_next  = bright_reg;

    pk  = evt.hit ? evt.key : pending_key;
    pending_key_next = pk;
    stp = step_ms(2'(edit_digit - DIGIT_FIRST));
    sum = {1'b0, preset} + (TIME_W + 1)'(stp);

    // key action
    case (mode_reg)
      MODE_SHOW: begin
        if (pk == KEY_GO) begin
          running_next  = 1'b1;
          mode_reg_next = MODE_RUN;
        end else if (pk == KEY_SETK) begin
          mode_reg_next   = MODE_SET;
          edit_digit_next = DIGIT_FIRST;
        end else if (pk == KEY_DN) begin
          bright_reg_next = (bright_reg < BRIGHT_MAX) ? bright_reg + 3'd1 : 3'd0;
        end
        pending_key_next = KEY_IDLE;
      end
      MODE_SET: begin
        if (pk == KEY_GO) begin
          edit_digit_next = (edit_digit < DIGIT_LAST) ? edit_digit + 3'd1 : DIGIT_FIRST;
        end else if (pk == KEY_SETK) begin
          mode_reg_next   = MODE_SHOW;
          remaining_next  = preset;
          edit_digit_next = DIGIT_FIRST;
        end else if (pk == KEY_UP) begin
          preset_next    = (sum > {1'b0, cfg.max_time}) ? cfg.max_time : sum[TIME_W-1:0];
          remaining_next = preset_next;
        end else if (pk == KEY_DN) begin
          preset_next    = (preset < TIME_W'(stp)) ? '0 : preset - TIME_W'(stp);
          remaining_next = preset_next;
        end
        pending_key_next = KEY_IDLE;
      end
      MODE_RUN: begin
        // only start is taken; other keys wait for another mode
        if (pk == KEY_GO) begin
          running_next     = 1'b0;
          mode_reg_next    = MODE_SHOW;
          remaining_next   = preset;
          pending_key_next = KEY_IDLE;
          beep_count_next  = cfg.beep_ticks;
          beep_flag_next   = 1'b1;
        end
      end
      default: ;
    endcase

    // countdown
    ad_inc = alarm_delay + 8'd1;
    if (running_next) begin
      if (remaining_next == '0) begin
        beep_flag_next  = 1'b1;
        beep_count_next = cfg.beep_ticks;
        remaining_next  = preset_next;
        running_next    = 1'b0;
        mode_reg_next   = MODE_SHOW;
      end else begin
        remaining_next = remaining_next - TIME_W'(1);
      end
      alarm_delay_next = ad_inc;
      if (ad_inc > cfg.alarm_interval) begin
        alarm_delay_next = '0;
        relay_reg_next   = alarm_in;
      end
    end else begin
      relay_reg_next = 1'b0;
    end
    if (beep_count_next == '0) beep_flag_next = 1'b0;
    else beep_count_next = beep_count_next - 10'd1;

    res_next.remaining_ms = remaining_next;
    res_next.set_ms       = preset_next;
    res_next.mode         = mode_reg_next;
    res_next.blink_digit  = (mode_reg_next == MODE_SET) ? edit_digit_next : 3'd0;
    res_next.run_led      = running_next;
    res_next.beep         = beep_flag_next;
    res_next.relay        = relay_reg_next;
    res_next.brightness   = bright_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_SHOW;
      running     <= 1'b0;
      remaining   <= TIME_DEFAULT;
      preset      <= TIME_DEFAULT;
      edit_digit  <= DIGIT_FIRST;
      pending_key <= KEY_IDLE;
      beep_count  <= '0;
      beep_flag   <= 1'b0;
      alarm_delay <= '0;
      relay_reg   <= 1'b0;
      bright_reg  <= '0;
    end else if (step) begin
      mode_reg    <= mode_reg_next;
      running     <= running_next;
      remaining   <= remaining_next;
      preset      <= preset_next;
      edit_digit  <= edit_digit_next;
      pending_key <= pending_key_next;
      beep_count  <= beep_count_next;
      beep_flag   <= beep_flag_next;
      alarm_delay <= alarm_delay_next;
      relay_reg   <= relay_reg_next;
      bright_reg  <= bright_reg_next;
    end
  end

endmodule

>>> hw/rtl/keypad_countdown_timer_controller_unit.sv
// Top level of the keypad countdown timer controller.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_stall  | key_code, alarm_in (one 1 ms tick)
//   out      | out_valid / out_stall| remaining_ms, set_ms, mode, blink_digit,
//            |                      | run_led, beep, relay, brightness
//   cfg      | cfg_write            | cfg_index, cfg_data (no read-back)
//
// Each transaction in gives one out, via the input and result registers.
// A new tick is taken every cycle while in_stall is low; the whole tick
// (debounce, key action, countdown) is one combinational pass between the
// input and result registers. Throughput is limited only by out_stall: while
// a result is held, the input register keeps one tick and in_stall rises once
// that register is full. Synchronous active-high reset clears all control
// state and loads the configuration defaults; no clearing pass is needed.
module keypad_countdown_timer_controller_unit
  import kctc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        key_code,
  input  logic              alarm_in,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TIME_W-1:0] remaining_ms,
  output logic [TIME_W-1:0] set_ms,
  output logic [1:0]        mode,
  output logic [2:0]        blink_digit,
  output logic              run_led,
  output logic              beep,
  output logic              relay,
  output logic [2:0]        brightness,
  // configuration
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cfg_t       cfg;
  logic       in_q_valid;
  logic [2:0] key_q;
  logic       alarm_q;
  logic       out_free;
  logic       step;
  key_evt_t   evt;
  result_t    res_next;
  result_t    res;

  // result slot can load when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign step     = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_samples <= DEBOUNCE_RST;
      cfg.beep_ticks       <= BEEP_RST;
      cfg.alarm_interval   <= ALARM_RST;
      cfg.max_time         <= MAX_TIME_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEBOUNCE: cfg.debounce_samples <= cfg_data[3:0];
        CFG_BEEP:     cfg.beep_ticks       <= cfg_data[9:0];
        CFG_ALARM:    cfg.alarm_interval   <= cfg_data[7:0];
        CFG_MAX_TIME: cfg.max_time         <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      key_q   <= key_code;
      alarm_q <= alarm_in;
    end
  end

  kctc_debounce u_debounce (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .key_code         (key_q),
    .debounce_samples (cfg.debounce_samples),
    .evt              (evt)
  );

  kctc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .evt      (evt),
    .alarm_in (alarm_q),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign remaining_ms = res.remaining_ms;
  assign set_ms       = res.set_ms;
  assign mode         = res.mode;
  assign blink_digit  = res.blink_digit;
  assign run_led      = res.run_led;
  assign beep         = res.beep;
  assign relay        = res.relay;
  assign brightness   = res.brightness;

endmodule

>>> hw/rtl/kctc_checker.sv
// Port-level checker for the timer controller, bound to the top level.
`include "assert_macros.svh"

module kctc_checker
  import kctc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [TIME_W-1:0] remaining_ms,
  input logic [TIME_W-1:0] set_ms,
  input logic [1:0]        mode,
  input logic [2:0]        blink_digit,
  input logic              run_led
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(remaining_ms) && $stable(set_ms) && $stable(mode))
  // running indicator tracks run mode
  `ASSERT_IMP(a_run_led_mode, clk, rst, out_valid, run_led == (mode == MODE_RUN))
  // blink digit is 1..4 while editing and 0 otherwise
  `ASSERT_IMP(a_blink_set, clk, rst, out_valid && mode == MODE_SET, blink_digit >= DIGIT_FIRST && blink_digit <= DIGIT_LAST)
  `ASSERT_IMP(a_blink_idle, clk, rst, out_valid && mode != MODE_SET, blink_digit == 3'd0)

endmodule

bind keypad_countdown_timer_controller_unit kctc_checker u_kctc_checker (.*);

>>> tb/sv/tb_keypad_countdown_timer_controller_unit.sv
// Self-checking testbench for the keypad countdown timer controller unit.
module tb_keypad_countdown_timer_controller_unit;
  import kctc_pkg::*;

  // Key codes outside the keypad range; the block treats them as a release.
  localparam logic [2:0] KEY_JUNK_LO  = 3'd5;
  localparam logic [2:0] KEY_JUNK_MID = 3'd6;
  localparam logic [2:0] KEY_JUNK_HI  = 3'd7;

  // Edit steps for digits 1..4.
  localparam int unsigned STEP_1S   = 1000;
  localparam int unsigned STEP_10S  = 10000;
  localparam int unsigned STEP_1MIN = 60000;
  localparam int unsigned STEP_10MIN = 600000;

  localparam int unsigned TIME_LIMIT = 4000000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        key_code;
  logic              alarm_in;
  logic              out_valid;
  logic              out_stall;
  logic [TIME_W-1:0] remaining_ms;
  logic [TIME_W-1:0] set_ms;
  logic [1:0]        mode;
  logic [2:0]        blink_digit;
  logic              run_led;
  logic              beep;
  logic              relay;
  logic [2:0]        brightness;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  keypad_countdown_timer_controller_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .key_code     (key_code),
    .alarm_in     (alarm_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .remaining_ms (remaining_ms),
    .set_ms       (set_ms),
    .mode         (mode),
    .blink_digit  (blink_digit),
    .run_led      (run_led),
    .beep         (beep),
    .relay        (relay),
    .brightness   (brightness),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Timer model state, kept in step with every accepted input transaction.
  // ---------------------------------------------------------------------------
  logic [3:0]        c_debounce = DEBOUNCE_RST;
  logic [9:0]        c_beep     = BEEP_RST;
  logic [7:0]        c_alarm    = ALARM_RST;
  logic [TIME_W-1:0] c_max      = MAX_TIME_RST;

  mode_t             p_mode      = MODE_SHOW;
  logic              p_running   = 1'b0;
  logic [TIME_W-1:0] p_remaining = TIME_DEFAULT;
  logic [TIME_W-1:0] p_preset    = TIME_DEFAULT;
  logic [2:0]        p_digit     = DIGIT_FIRST;
  logic [2:0]        p_pending   = KEY_IDLE;
  logic              p_lock [KEYS] = '{default: 1'b0};
  logic [3:0]        p_count [KEYS] = '{default: 4'd0};
  logic [9:0]        p_beep_cnt  = 10'd0;
  logic              p_beep_on   = 1'b0;
  logic [7:0]        p_alarm_div = 8'd0;
  logic              p_relay     = 1'b0;
  logic [2:0]        p_bright    = 3'd0;

  // Panel states predicted for transactions taken in, oldest first.
  result_t panel_states [$];

  int errors       = 0;
  int results_seen = 0;
  int calm_left    = 0;

  // One 1 ms tick: debounce, key action for the current mode, countdown.
  function automatic result_t tick_timer(input logic [2:0] key, input logic alarm);
    logic [TIME_W-1:0] step;
    logic [TIME_W:0]   sum;
    logic [3:0]        old;
    int                k;
    logic [1:0]        sel;
    result_t           r;
    // Debounce: per-key counter with self-lock; anything else releases all keys.
    if (key >= KEY_GO && key <= KEY_DN) begin
      k = int'(key - KEY_GO);
      if (!p_lock[k]) begin
        old = p_count[k];
        if (p_count[k] < COUNT_MAX) p_count[k] = p_count[k] + 4'd1;
        if (old > c_debounce) begin
          p_lock[k]  = 1'b1;
          p_count[k] = 4'd0;
          p_pending  = key;
        end
      end
    end else begin
      for (k = 0; k < KEYS; k++) begin
        p_lock[k]  = 1'b0;
        p_count[k] = 4'd0;
      end
    end
    // Key action.
    sel = 2'(p_digit - DIGIT_FIRST);
    case (sel)
      2'd0:    step = TIME_W'(STEP_1S);
      2'd1:    step = TIME_W'(STEP_10S);
      2'd2:    step = TIME_W'(STEP_1MIN);
      default: step = TIME_W'(STEP_10MIN);
    endcase
    case (p_mode)
      MODE_SHOW: begin
        if (p_pending == KEY_GO) begin
          p_running = 1'b1;
          p_mode    = MODE_RUN;
        end else if (p_pending == KEY_SETK) begin
          p_mode  = MODE_SET;
          p_digit = DIGIT_FIRST;
        end else if (p_pending == KEY_DN) begin
          p_bright = (p_bright < BRIGHT_MAX) ? p_bright + 3'd1 : 3'd0;
        end
        p_pending = KEY_IDLE;
      end
      MODE_SET: begin
        if (p_pending == KEY_GO) begin
          p_digit = (p_digit < DIGIT_LAST) ? p_digit + 3'd1 : DIGIT_FIRST;
        end else if (p_pending == KEY_SETK) begin
          p_mode      = MODE_SHOW;
          p_remaining = p_preset;
          p_digit     = DIGIT_FIRST;
        end else if (p_pending == KEY_UP) begin
          // One spare bit: the sum may pass the 23-bit range before saturating.
          sum = {1'b0, p_preset} + {1'b0, step};
          if (sum > {1'b0, c_max}) sum = {1'b0, c_max};
          p_preset    = sum[TIME_W-1:0];
          p_remaining = p_preset;
        end else if (p_pending == KEY_DN) begin
          p_preset    = (p_preset < step) ? '0 : p_preset - step;
          p_remaining = p_preset;
        end
        p_pending = KEY_IDLE;
      end
      MODE_RUN: begin
        // Only start is served here; other keys wait for the next mode.
        if (p_pending == KEY_GO) begin
          p_running   = 1'b0;
          p_mode      = MODE_SHOW;
          p_remaining = p_preset;
          p_pending   = KEY_IDLE;
          p_beep_cnt  = c_beep;
          p_beep_on   = 1'b1;
        end
      end
      default: ;
    endcase
    // Countdown, relay sampling and beeper.
    if (p_running) begin
      if (p_remaining == '0) begin
        p_beep_on   = 1'b1;
        p_beep_cnt  = c_beep;
        p_remaining = p_preset;
        p_running   = 1'b0;
        p_mode      = MODE_SHOW;
      end else begin
        p_remaining = p_remaining - TIME_W'(1);
      end
      // Relay sampling still runs on the expiry tick.
      p_alarm_div = p_alarm_div + 8'd1;
      if (p_alarm_div > c_alarm) begin
        p_alarm_div = 8'd0;
        p_relay     = alarm;
      end
    end else begin
      p_relay = 1'b0;
    end
    if (p_beep_cnt == 10'd0) p_beep_on = 1'b0;
    else p_beep_cnt = p_beep_cnt - 10'd1;
    r.remaining_ms = p_remaining;
    r.set_ms       = p_preset;
    r.mode         = p_mode;
    r.blink_digit  = (p_mode == MODE_SET) ? p_digit : 3'd0;
    r.run_led      = p_running;
    r.beep         = p_beep_on;
    r.relay        = p_relay;
    r.brightness   = p_bright;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed part. Rows flagged typed carry a panel state read straight off
  // the spec; the rest are checked against the timer model.
  // Runs with debounce 1, beep 3, alarm interval 1, max time 3 ms.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [2:0] key;
    logic       alarm;
    logic       typed;
    result_t    want;
  } drill_t;

  localparam result_t PANEL_RESET = '{
    remaining_ms: TIME_DEFAULT, set_ms: TIME_DEFAULT, mode: MODE_SHOW,
    blink_digit: 3'd0, run_led: 1'b0, beep: 1'b0, relay: 1'b0, brightness: 3'd0};

  localparam int DRILL_LEN = 26;
  localparam drill_t DRILL [DRILL_LEN] = '{
    // reset panel, unknown codes release without effect
    '{KEY_IDLE,     1'b0, 1'b1, PANEL_RESET},
    '{KEY_JUNK_HI,  1'b1, 1'b1, PANEL_RESET},
    '{KEY_JUNK_LO,  1'b0, 1'b1, PANEL_RESET},
    // show: down bumps brightness
    '{KEY_DN,       1'b0, 1'b0, PANEL_RESET},
    '{KEY_DN,       1'b1, 1'b0, PANEL_RESET},
    '{KEY_DN,       1'b0, 1'b0, PANEL_RESET},
    // show -> set
    '{KEY_SETK,     1'b1, 1'b0, PANEL_RESET},
    '{KEY_SETK,     1'b0, 1'b0, PANEL_RESET},
    '{KEY_SETK,     1'b1, 1'b0, PANEL_RESET},
    // up with set time above max time loads max time
    '{KEY_UP,       1'b0, 1'b0, PANEL_RESET},
    '{KEY_UP,       1'b0, 1'b0, PANEL_RESET},
    '{KEY_UP,       1'b1, 1'b0, PANEL_RESET},
    // start selects the next digit
    '{KEY_GO,       1'b0, 1'b0, PANEL_RESET},
    '{KEY_GO,       1'b1, 1'b0, PANEL_RESET},
    '{KEY_GO,       1'b0, 1'b0, PANEL_RESET},
    '{KEY_JUNK_MID, 1'b0, 1'b0, PANEL_RESET},
    // set -> show, remaining reloaded
    '{KEY_SETK,     1'b0, 1'b0, PANEL_RESET},
    '{KEY_SETK,     1'b1, 1'b0, PANEL_RESET},
    '{KEY_SETK,     1'b0, 1'b0, PANEL_RESET},
    // show -> run
    '{KEY_GO,       1'b1, 1'b0, PANEL_RESET},
    '{KEY_GO,       1'b1, 1'b0, PANEL_RESET},
    '{KEY_GO,       1'b1, 1'b0, PANEL_RESET},
    // down while running stays pending; expiry with relay sample and beeper
    '{KEY_DN,       1'b1, 1'b0, PANEL_RESET},
    '{KEY_DN,       1'b0, 1'b0, PANEL_RESET},
    '{KEY_DN,       1'b1, 1'b0, PANEL_RESET},
    // back in show: the pending down is served
    '{KEY_IDLE,     1'b0, 1'b0, PANEL_RESET}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset and time limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIME_LIMIT);
    $display("tb_keypad_countdown_timer_controller_unit: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Idle cycles before the next tick: mostly none or short, a few long,
  // and now and then a run of back-to-back transactions.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = 30;
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [2:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return KEY_GO;
    if (r < 55) return KEY_SETK;
    if (r < 75) return KEY_UP;
    return KEY_DN;
  endfunction

  // Offer one tick and hold it until taken; the model advances on acceptance.
  task automatic offer_tick(input logic [2:0] k, input logic a, input logic typed,
                            input result_t want);
    int      gap;
    result_t guess;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key_code <= k;
    alarm_in <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = tick_timer(k, a);
    panel_states.push_back(typed ? want : guess);
  endtask

  // Register write; the caller drops cfg_write after the last one.
  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    logic [CFG_W-1:0] mask;
    logic [CFG_W-1:0] word;
    case (idx)
      CFG_DEBOUNCE: mask = 23'h00000F;
      CFG_BEEP:     mask = 23'h0003FF;
      CFG_ALARM:    mask = 23'h0000FF;
      default:      mask = 23'h7FFFFF;
    endcase
    // Junk above the register width must be ignored.
    word = (CFG_W'($urandom) & ~mask) | (CFG_W'(val) & mask);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE: c_debounce = word[3:0];
      CFG_BEEP:     c_beep     = word[9:0];
      CFG_ALARM:    c_alarm    = word[7:0];
      default:      c_max      = word;
    endcase
  endtask

  task automatic load_setup(input int unsigned deb, input int unsigned bticks,
                            input int unsigned alarm_gap, input int unsigned tmax);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_BEEP, bticks);
    write_reg(CFG_ALARM, alarm_gap);
    write_reg(CFG_MAX_TIME, tmax);
    cfg_write <= 1'b0;
  endtask

  // Drain all outstanding results before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (panel_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random ticks: mostly clean presses long enough to be accepted, then a
  // short release; some presses cut short and some bursts of raw codes.
  task automatic run_phase(input int budget);
    int         sent;
    int         n;
    int         i;
    int         r;
    logic [2:0] k;
    logic [2:0] rel;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        k = pick_key();
        if (r < 78) n = c_debounce + 2 + $urandom_range(0, 2);
        else n = $urandom_range(1, c_debounce + 1);
        for (i = 0; i < n; i++) offer_tick(k, 1'($urandom_range(0, 1)), 1'b0, PANEL_RESET);
        sent += n;
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
          rel = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(KEY_JUNK_LO, KEY_JUNK_HI))
                                            : KEY_IDLE;
          offer_tick(rel, 1'($urandom_range(0, 1)), 1'b0, PANEL_RESET);
        end
        sent += n;
      end else begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          offer_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b0,
                     PANEL_RESET);
        end
        sent += n;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    key_code  <= KEY_IDLE;
    alarm_in  <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    load_setup(1, 3, 1, 3);
    for (i = 0; i < DRILL_LEN; i++) begin
      offer_tick(DRILL[i].key, DRILL[i].alarm, DRILL[i].typed, DRILL[i].want);
    end

    // Low extremes: zero max time, so any up press clamps the set time to zero.
    settle();
    load_setup(1, 0, 1, 0);
    run_phase(200);

    // Top debounce never accepts a key; counters saturate.
    settle();
    load_setup(15, 1023, 255, 8388607);
    run_phase(60);

    // High extremes with keys accepted; alarm divider never fires.
    settle();
    load_setup(2, 1023, 255, 8388607);
    run_phase(250);

    settle();
    load_setup($urandom_range(1, 4), $urandom_range(0, 40), $urandom_range(1, 255),
               $urandom_range(0, 40000));
    run_phase(150);

    settle();
    load_setup($urandom_range(1, 6), $urandom_range(0, 1023), $urandom_range(1, 255),
               $urandom_range(0, 8388607));
    run_phase(150);

    in_valid <= 1'b0;
    i = 0;
    while (panel_states.size() != 0 && i < 20000) begin
      @(posedge clk);
      i++;
    end
    repeat (8) @(posedge clk);
    if (panel_states.size() != 0) begin
      errors++;
      $display("%0t: %0d expected transactions never arrived", $time, panel_states.size());
    end
    if (errors == 0) begin
      $display("tb_keypad_countdown_timer_controller_unit: PASS");
    end else begin
      $display("tb_keypad_countdown_timer_controller_unit: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stall runs, plus one long hold-off early on so the
  // input side backs up while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    int free;
    bit squeezed;
    hold = 0;
    free = 0;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!squeezed && results_seen >= 100) begin
        squeezed = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (free > 0) begin
        out_stall <= 1'b0;
        free--;
      end else begin
        out_stall <= 1'b0;
        free = ($urandom_range(0, 99) < 10) ? 60 : $urandom_range(0, 8);
        hold = ($urandom_range(0, 99) < 6) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // Compare each result transaction against the oldest prediction.
  always @(posedge clk) begin : watch_panel
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (panel_states.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing expected", $time);
      end else begin
        want = panel_states.pop_front();
        check_field("remaining_ms", 32'(want.remaining_ms), 32'(remaining_ms));
        check_field("set_ms", 32'(want.set_ms), 32'(set_ms));
        check_field("mode", 32'(want.mode), 32'(mode));
        check_field("blink_digit", 32'(want.blink_digit), 32'(blink_digit));
        check_field("run_led", 32'(want.run_led), 32'(run_led));
        check_field("beep", 32'(want.beep), 32'(beep));
        check_field("relay", 32'(want.relay), 32'(relay));
        check_field("brightness", 32'(want.brightness), 32'(brightness));
      end
    end
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/kctc_pkg.sv
hw/rtl/kctc_debounce.sv
hw/rtl/kctc_ctrl.sv
hw/rtl/keypad_countdown_timer_controller_unit.sv
hw/rtl/kctc_checker.sv
tb/sv/tb_keypad_countdown_timer_controller_unit.sv
